@@ rtl/four_level_page_walk_unit_assert.svh @@
// Assertion macros for the four-level page walk unit.
// Included by the top level; no other dependencies.
`ifndef FOUR_LEVEL_PAGE_WALK_UNIT_ASSERT_SVH
`define FOUR_LEVEL_PAGE_WALK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FLPW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FLPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/flpw_pkg.sv @@
// Shared types and constants for the four-level page walk unit.
// No dependencies.
`default_nettype none

package flpw_pkg;

    localparam int PA_W            = 52;
    localparam int LIN_W           = 48;
    localparam int ENTRY_W         = 64;
    localparam int IDX_W           = 9;
    localparam int OFF_W           = 12;
    localparam int PTR_W           = PA_W - OFF_W;   // entry bits 51:12
    localparam int WORD_W          = PA_W - 3;       // 8-byte word address
    localparam int PAGE_BIT        = 7;
    localparam int ENTRY_DEPTH_DEF = 4096;

    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_1G   = 2'd1;
    localparam logic [1:0] KIND_2M   = 2'd2;
    localparam logic [1:0] KIND_4K   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PML4,
        ST_PDPT,
        ST_PD,
        ST_PT,
        ST_LEAF
    } walk_state_t;

    // Request from the walker to the entry store.
    typedef struct packed {
        logic               rd_en;
        logic [WORD_W-1:0]  rd_word;
        logic               wr_en;
        logic [WORD_W-1:0]  wr_word;
        logic [ENTRY_W-1:0] wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/four_level_page_walk_unit.sv @@
// Top level of the four-level page walk unit: stream ports, root register.
// Depends on flpw_pkg, flpw_walker, flpw_entry_mem and the assertion header.
`default_nettype none

// Four-level page-table walker over an on-chip store of ENTRY_DEPTH 64-bit
// entries (word n covers physical bytes 8n..8n+7). A write word (command 0)
// stores entry_value at address[51:3] and gives no result. A translate
// word (command 1) walks PML4, PDPT, directory and table from table_root
// (low 12 bits ignored); bit 7 at PDPT, directory or table ends the walk
// with a 1 GiB, 2 MiB or 4 KiB page, and a table entry without bit 7
// gives address 0, kind 0. Present bits are not checked, and reads past
// the store return zero. Each level is one read of the single store port
// with registered data, so a translate holds the input from accept until
// its walk ends, plus any wait on m_tready for the result register.
// After reset a clearing sweep zeroes the store at one entry per cycle,
// and s_tready stays low until it is done; table_root writes are taken
// at any time but should be made only while the unit is idle.
module four_level_page_walk_unit
    import flpw_pkg::*;
#(
    parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // root register write
    input  wire logic               root_we,
    input  wire logic [PA_W-1:0]    root_wdata,
    // input words
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [119:0]       s_tdata,   // address[51:0], entry_value[115:52], zero pad
    input  wire logic [0:0]         s_tuser,   // command[0]
    // result words
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [55:0]             m_tdata,   // physical_address[51:0], zero pad
    output logic [1:0]              m_tuser    // page_kind[1:0]
);

    logic [PA_W-1:0]    table_root_reg;
    logic [PA_W-1:0]    table_root_next;
    mem_req_t           mem_req;
    logic               mem_ready;
    logic [ENTRY_W-1:0] rd_data;
    logic [PA_W-1:0]    out_pa;

    assign table_root_next = root_we ? root_wdata : table_root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_root_reg <= '0;
        end
        else
        begin
            table_root_reg <= table_root_next;
        end
    end

    flpw_walker u_walker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .table_root           (table_root_reg),
        .in_valid             (s_tvalid),
        .in_ready             (s_tready),
        .in_command           (s_tuser[0]),
        .in_address           (s_tdata[51:0]),
        .in_entry_value       (s_tdata[115:52]),
        .out_valid            (m_tvalid),
        .out_ready            (m_tready),
        .out_physical_address (out_pa),
        .out_page_kind        (m_tuser),
        .mem_ready            (mem_ready),
        .mem_req              (mem_req),
        .rd_data              (rd_data)
    );

    flpw_entry_mem #(
        .ENTRY_DEPTH (ENTRY_DEPTH)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .ready   (mem_ready),
        .rd_data (rd_data)
    );

    assign m_tdata = {4'b0, out_pa};

`include "four_level_page_walk_unit_assert.svh"

    // no words taken while the clearing sweep runs
    `FLPW_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, !mem_ready, !s_tready, "accept during clear")
    // unmapped results carry address zero
    `FLPW_ASSERT_NOW(a_unmapped_zero, clk, rst_n, m_tvalid && (m_tuser == KIND_NONE), out_pa == '0, "unmapped result with nonzero address")
    // a translate occupies the unit on the following cycle
    `FLPW_ASSERT_NEXT(a_walk_busy, clk, rst_n, s_tvalid && s_tready && (s_tuser[0] == CMD_TRANSLATE), !s_tready, "ready right after translate")
    // a write finishes in its accept cycle
    `FLPW_ASSERT_NEXT(a_write_one_cycle, clk, rst_n, s_tvalid && s_tready && (s_tuser[0] == CMD_WRITE), s_tready, "not ready after write")

endmodule

`default_nettype wire

@@ rtl/flpw_entry_mem.sv @@
// Entry store: table memory with one read and one write port, and a clearing sweep after reset.
// Depends on flpw_pkg.
`default_nettype none

module flpw_entry_mem
    import flpw_pkg::*;
#(
    parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mem_req_t           req,
    output logic                    ready,     // clear sweep done
    output logic [ENTRY_W-1:0]      rd_data
);

    localparam int AW = $clog2(ENTRY_DEPTH);
    localparam logic [WORD_W-1:0] DEPTH_W = WORD_W'(ENTRY_DEPTH);
    localparam logic [AW-1:0]     LAST_IDX = AW'(ENTRY_DEPTH - 1);

    logic [ENTRY_W-1:0] mem [ENTRY_DEPTH];

    logic               clear_busy_reg;
    logic               clear_busy_next;
    logic [AW-1:0]      clr_idx_reg;
    logic [AW-1:0]      clr_idx_next;
    logic [ENTRY_W-1:0] rd_q_reg;
    logic               rd_hit_reg;
    logic               wr_hit;
    logic               rd_hit;

    // words past the end of the store: writes dropped, reads give zero
    assign wr_hit = req.wr_word < DEPTH_W;
    assign rd_hit = req.rd_word < DEPTH_W;

    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clr_idx_next    = clr_idx_reg;
        if (clear_busy_reg)
        begin
            if (clr_idx_reg == LAST_IDX)
            begin
                clear_busy_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (req.wr_en && wr_hit)
        begin
            mem[req.wr_word[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en && rd_hit)
        begin
            rd_q_reg <= mem[req.rd_word[AW-1:0]];
        end
        if (req.rd_en)
        begin
            rd_hit_reg <= rd_hit;
        end
    end

    assign ready   = !clear_busy_reg;
    assign rd_data = rd_hit_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

@@ rtl/flpw_walker.sv @@
// Walk sequencer: one read per level through a shared address former and
// one shared 52-bit adder for the final address. Depends on flpw_pkg.
`default_nettype none

module flpw_walker
    import flpw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [PA_W-1:0]    table_root,
    // input word
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_command,
    input  wire logic [PA_W-1:0]    in_address,
    input  wire logic [ENTRY_W-1:0] in_entry_value,
    // result word
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [PA_W-1:0]         out_physical_address,
    output logic [1:0]              out_page_kind,
    // entry store
    input  wire logic               mem_ready,
    output mem_req_t                mem_req,
    input  wire logic [ENTRY_W-1:0] rd_data
);

    walk_state_t       state_reg;
    walk_state_t       state_next;
    logic [LIN_W-1:0]  lin_reg;
    logic              out_valid_reg;
    logic [PA_W-1:0]   out_pa_reg;
    logic [1:0]        out_kind_reg;

    logic              accept;
    logic              out_free;
    logic              is_page;
    logic [PTR_W-1:0]  base;
    logic [IDX_W-1:0]  idx;
    logic [PA_W-1:0]   offset;
    logic [PA_W-1:0]   sum;
    logic              rd_issue;
    logic              fin;
    logic [PA_W-1:0]   fin_pa;
    logic [1:0]        fin_kind;

    assign in_ready = (state_reg == ST_IDLE) && mem_ready;
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign is_page  = rd_data[PAGE_BIT];

    // table base: root for the first level, else pointer of the last entry
    assign base = (state_reg == ST_PML4) ? table_root[PA_W-1:OFF_W] : rd_data[PA_W-1:OFF_W];

    always_comb
    begin
        idx    = lin_reg[47:39];
        offset = '0;
        case (state_reg)
            ST_PML4: idx = lin_reg[47:39];
            ST_PDPT: idx = lin_reg[38:30];
            ST_PD:
            begin
                idx    = lin_reg[29:21];
                offset = PA_W'(lin_reg[29:0]);
            end
            ST_PT:
            begin
                idx    = lin_reg[20:12];
                offset = PA_W'(lin_reg[20:0]);
            end
            ST_LEAF: offset = PA_W'(lin_reg[11:0]);
            default: idx = lin_reg[47:39];
        endcase
    end

    // shared adder, wraps at 52 bits
    assign sum = {rd_data[PA_W-1:OFF_W], {OFF_W{1'b0}}} + offset;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_command == CMD_TRANSLATE)
                begin
                    state_next = ST_PML4;
                end
            end
            ST_PML4: state_next = ST_PDPT;
            ST_PDPT: state_next = ST_PD;
            ST_PD:
            begin
                if (!is_page)
                begin
                    state_next = ST_PT;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PT:
            begin
                if (!is_page)
                begin
                    state_next = ST_LEAF;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LEAF:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        rd_issue = 1'b0;
        fin      = 1'b0;
        fin_pa   = '0;
        fin_kind = KIND_NONE;
        case (state_reg)
            ST_IDLE: rd_issue = 1'b0;
            ST_PML4: rd_issue = 1'b1;
            ST_PDPT: rd_issue = 1'b1;
            ST_PD:
            begin
                rd_issue = !is_page;
                fin      = is_page && out_free;
                fin_pa   = sum;
                fin_kind = KIND_1G;
            end
            ST_PT:
            begin
                rd_issue = !is_page;
                fin      = is_page && out_free;
                fin_pa   = sum;
                fin_kind = KIND_2M;
            end
            ST_LEAF:
            begin
                fin      = out_free;
                fin_pa   = is_page ? sum : '0;
                fin_kind = is_page ? KIND_4K : KIND_NONE;
            end
            default: rd_issue = 1'b0;
        endcase
    end

    assign mem_req.rd_en   = rd_issue;
    assign mem_req.rd_word = {base, idx};
    assign mem_req.wr_en   = accept && (in_command == CMD_WRITE);
    assign mem_req.wr_word = in_address[PA_W-1:3];
    assign mem_req.wr_data = in_entry_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lin_reg <= in_address[LIN_W-1:0];
        end
        if (fin)
        begin
            out_pa_reg   <= fin_pa;
            out_kind_reg <= fin_kind;
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_physical_address = out_pa_reg;
    assign out_page_kind        = out_kind_reg;

endmodule

`default_nettype wire

@@ tb/four_level_page_walk_unit_test.sv @@
// Self-checking testbench for four_level_page_walk_unit: table-entry writes and
// translates on the stream ports, checked against an in-bench walk predictor.
// Depends on flpw_pkg and the RTL of four_level_page_walk_unit.
`default_nettype none

module four_level_page_walk_unit_test;
    import flpw_pkg::*;

    localparam int          DEPTH     = ENTRY_DEPTH_DEF;
    localparam int          TABLES    = DEPTH / 512;          // 4 KiB tables held by the store
    localparam logic [63:0] PTR_FIELD = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] LOW_MASK  = 64'h0000_0000_0000_0FFF;

    // One translation as the block reports it.
    typedef struct packed {
        logic [PA_W-1:0] phys;
        logic [1:0]      kind;
    } translation_t;

    logic               clk;
    logic               rst_n;
    logic               root_we;
    logic [PA_W-1:0]    root_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [119:0]       s_tdata;    // address[51:0], entry_value[115:52], zero pad
    logic [0:0]         s_tuser;    // command[0]
    logic               m_tvalid;
    logic               m_tready;
    logic [55:0]        m_tdata;    // physical_address[51:0], zero pad
    logic [1:0]         m_tuser;    // page_kind[1:0]

    // Predictor state: shadow of the entry store and of the root register.
    logic [63:0]        entry_copy [DEPTH];
    logic [PA_W-1:0]    root_copy;
    translation_t       pending_translations [$];
    translation_t       oldest;

    int                 mismatches;
    int                 words_sent;
    int                 hold_cycles;
    bit                 sender_steady;
    bit                 receiver_steady;

    four_level_page_walk_unit #(
        .ENTRY_DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .root_we   (root_we),
        .root_wdata(root_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Walk predictor
    // ------------------------------------------------------------------

    // Entry fetch: word = table base / 8 + index; past the store reads zero.
    function automatic logic [63:0] fetch_entry(input logic [63:0] table_base,
                                                input logic [IDX_W-1:0] idx);
        logic [63:0] word;
        word = (table_base >> 3) + {55'b0, idx};
        if (word >= 64'(DEPTH))
            return 64'b0;
        return entry_copy[word];
    endfunction

    function automatic translation_t walk_translate(input logic [PA_W-1:0] lin);
        logic [63:0]  base;
        logic [63:0]  ent;
        logic [63:0]  sum;
        translation_t res;
        res  = '0;
        sum  = 64'b0;
        base = {12'b0, root_copy} & ~LOW_MASK;
        // PML4 always links; its bit 7 is not looked at
        ent  = fetch_entry(base, lin[47:39]);
        base = ent & PTR_FIELD;
        ent  = fetch_entry(base, lin[38:30]);
        if (ent[PAGE_BIT]) begin
            sum      = (ent & PTR_FIELD) + {34'b0, lin[29:0]};
            res.kind = KIND_1G;
        end
        else begin
            base = ent & PTR_FIELD;
            ent  = fetch_entry(base, lin[29:21]);
            if (ent[PAGE_BIT]) begin
                sum      = (ent & PTR_FIELD) + {43'b0, lin[20:0]};
                res.kind = KIND_2M;
            end
            else begin
                base = ent & PTR_FIELD;
                ent  = fetch_entry(base, lin[20:12]);
                // last level without bit 7: address 0, unmapped
                if (ent[PAGE_BIT]) begin
                    sum      = (ent & PTR_FIELD) + {52'b0, lin[11:0]};
                    res.kind = KIND_4K;
                end
            end
        end
        res.phys = sum[PA_W-1:0];    // wraps to 52 bits
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Idle length: mostly none, some short, a few long.
    function automatic int pick_gap(input bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [PA_W-1:0] linear(input logic [3:0] hi, input logic [8:0] i4,
                                               input logic [8:0] i3, input logic [8:0] i2,
                                               input logic [8:0] i1, input logic [11:0] off);
        return {hi, i4, i3, i2, i1, off};
    endfunction

    // Byte address of an entry, sometimes with junk in the low 3 bits.
    function automatic logic [PA_W-1:0] entry_addr(input logic [63:0] table_base,
                                                   input logic [8:0] idx);
        logic [63:0] a;
        a = table_base + {52'b0, idx, 3'b0};
        if ($urandom_range(0, 3) == 0)
            a = a + 64'($urandom_range(1, 7));
        return a[PA_W-1:0];
    endfunction

    // Non-leaf entry pointing at table slot; now and then a pointer off the store.
    function automatic logic [63:0] link_entry(input int slot);
        logic [63:0] v;
        v = rand64();
        if ($urandom_range(0, 9) != 0)
            v[51:12] = 40'(slot);
        v[PAGE_BIT] = 1'b0;
        return v;
    endfunction

    function automatic logic [63:0] leaf_entry();
        logic [63:0] v;
        v = rand64();
        v[PAGE_BIT] = 1'b1;
        return v;
    endfunction

    function automatic logic [63:0] plain_entry();
        logic [63:0] v;
        v = rand64();
        v[PAGE_BIT] = 1'b0;
        return v;
    endfunction

    // Offer one word and hold it until accepted; valid stays high afterwards
    // so back-to-back words need no extra edge.
    task automatic send_word(input logic cmd, input logic [PA_W-1:0] addr,
                             input logic [63:0] value);
        int          gap;
        logic [63:0] word;
        gap = pick_gap(sender_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, value, addr};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (cmd == CMD_TRANSLATE) begin
            pending_translations.push_back(walk_translate(addr));
        end
        else begin
            word = {15'b0, addr[PA_W-1:3]};
            if (word < 64'(DEPTH))
                entry_copy[word] = value;
        end
    endtask

    // Drop valid, wait for all results, then cover a trailing table write.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_translations.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Only called with the unit idle.
    task automatic write_root(input logic [PA_W-1:0] value);
        root_we    <= 1'b1;
        root_wdata <= value;
        @(posedge clk);
        root_we    <= 1'b0;
        root_copy   = value;
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch: %s got %h want %h", what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, plus a long hold-off when asked for
    // ------------------------------------------------------------------
    initial
    begin : result_ready
        int stall;
        m_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (receiver_steady) begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else begin
                stall = pick_gap(1'b0);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest pending translation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_translations.size() == 0) begin
                flag_mismatch("result with no pending translate", {8'b0, m_tdata}, 64'b0);
            end
            else begin
                oldest = pending_translations.pop_front();
                if (m_tdata[PA_W-1:0] !== oldest.phys)
                    flag_mismatch("physical_address", {12'b0, m_tdata[PA_W-1:0]},
                                  {12'b0, oldest.phys});
                if (m_tuser !== oldest.kind)
                    flag_mismatch("page_kind", {62'b0, m_tuser}, {62'b0, oldest.kind});
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty store: every walk reads zeros and ends unmapped.
    task automatic test_empty_store();
        settle_idle();
        write_root('0);
        send_word(CMD_TRANSLATE, '0, '0);
        send_word(CMD_TRANSLATE, '1, '1);
    endtask

    // One walk of each page size plus an unmapped last level.
    // Root 0x1FFF: low bits must be masked, tables at 0x1000..0x4000.
    task automatic test_page_sizes();
        settle_idle();
        write_root(52'h0_0000_0000_1FFF);
        // PML4 entry with bit 7 set still links
        send_word(CMD_WRITE, 52'h1000, 64'hFFF0_0000_0000_20FF);
        // 1 GiB page, top pointer, full offset: the sum wraps
        send_word(CMD_WRITE, 52'h2000, 64'h800F_FFFF_FFFF_F080);
        send_word(CMD_TRANSLATE, linear(4'h0, 9'd0, 9'd0, 9'h1FF, 9'h1FF, 12'hFFF), '0);
        // 2 MiB page
        send_word(CMD_WRITE, 52'h2008, 64'h0000_0000_0000_3000);
        send_word(CMD_WRITE, 52'h3000, 64'h0000_0ABC_DE00_0080);
        send_word(CMD_TRANSLATE, linear(4'h0, 9'd0, 9'd1, 9'd0, 9'h1FF, 12'hFFF), '0);
        // 4 KiB page at the last index of the table
        send_word(CMD_WRITE, 52'h3008, 64'h0000_0000_0000_4000);
        send_word(CMD_WRITE, 52'h4FF8, 64'h7FF0_1234_5678_9FFF);
        send_word(CMD_TRANSLATE, linear(4'h0, 9'd0, 9'd1, 9'd1, 9'd511, 12'hFFF), '0);
        // last level entry still zero: unmapped
        send_word(CMD_TRANSLATE, linear(4'h0, 9'd0, 9'd1, 9'd1, 9'd0, 12'h123), '0);
    endtask

    // Unaligned and out-of-range writes, reads past the store, high linear bits.
    task automatic test_store_edges();
        // unaligned: lands on table entry 3
        send_word(CMD_WRITE, 52'h401D, 64'h0000_0000_0055_5080);
        send_word(CMD_TRANSLATE, linear(4'h0, 9'd0, 9'd1, 9'd1, 9'd3, 12'h7A5), '0);
        // both ignored, the store ends at byte 0x7FFF
        send_word(CMD_WRITE, 52'h8000, '0);
        send_word(CMD_WRITE, '1, '1);
        // directory pointer past the store: that read gives zero
        send_word(CMD_WRITE, 52'h2010, 64'h0000_0000_0000_8003);
        send_word(CMD_TRANSLATE, linear(4'h0, 9'd0, 9'd2, 9'd5, 9'd7, 12'h123), '0);
        // bits 51:48 of a linear address play no part
        send_word(CMD_TRANSLATE, linear(4'hF, 9'd0, 9'd1, 9'd1, 9'd511, 12'hABC), '0);
        // root past the store
        settle_idle();
        write_root('1);
        send_word(CMD_TRANSLATE, '0, '0);
        send_word(CMD_TRANSLATE, linear(4'h5, 9'h1FF, 9'd1, 9'd1, 9'd3, 12'h001), '1);
    endtask

    // Mostly well-formed table chains with random content, then translates
    // through them; the rest is noise and chains with a link left out.
    task automatic run_walk_phase(input logic [PA_W-1:0] root, input int quota, input bit calm);
        int              phase_end;
        int              depth;
        int              slot [4];
        logic [8:0]      ix [4];
        logic [63:0]     root_base;
        logic [PA_W-1:0] lin;
        settle_idle();
        write_root(root);
        sender_steady   = calm;
        receiver_steady = calm;
        root_base = {12'b0, root} & ~LOW_MASK;
        phase_end = words_sent + quota;
        while (words_sent < phase_end)
        begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                    0:       send_word(CMD_WRITE, PA_W'(rand64()), rand64());
                    1:       send_word(CMD_WRITE, PA_W'($urandom_range(0, DEPTH * 8 - 1)),
                                       rand64());
                    default: send_word(CMD_TRANSLATE, PA_W'(rand64()), rand64());
                endcase
            end
            else begin
                // 1: 1 GiB, 2: 2 MiB, 3: 4 KiB, 4: last level not a page
                depth = $urandom_range(1, 4);
                for (int l = 0; l < 4; l++) begin
                    ix[l]   = 9'($urandom);
                    slot[l] = $urandom_range(0, TABLES - 1);
                end
                if ($urandom_range(0, 9) != 0)
                    send_word(CMD_WRITE, entry_addr(root_base, ix[0]), link_entry(slot[1]));
                send_word(CMD_WRITE, entry_addr(64'(slot[1]) * 4096, ix[1]),
                          depth == 1 ? leaf_entry() : link_entry(slot[2]));
                if (depth >= 2)
                    send_word(CMD_WRITE, entry_addr(64'(slot[2]) * 4096, ix[2]),
                              depth == 2 ? leaf_entry() : link_entry(slot[3]));
                if (depth >= 3)
                    send_word(CMD_WRITE, entry_addr(64'(slot[3]) * 4096, ix[3]),
                              depth == 3 ? leaf_entry() : plain_entry());
                repeat ($urandom_range(1, 3))
                begin
                    lin = linear(4'($urandom), ix[0], ix[1], ix[2], ix[3], 12'($urandom));
                    if (depth == 1)
                        lin[29:0] = 30'($urandom);
                    else if (depth == 2)
                        lin[20:0] = 21'($urandom);
                    send_word(CMD_TRANSLATE, lin, rand64());
                end
            end
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    task automatic test_random_walks();
        run_walk_phase('0, 300, 1'b0);
        run_walk_phase({37'b0, 3'($urandom_range(0, TABLES - 1)), 12'($urandom)}, 300, 1'b1);
        run_walk_phase(52'h0_0000_0000_7FFF, 300, 1'b0);
        run_walk_phase('1, 120, 1'b0);
        run_walk_phase(PA_W'(rand64()), 100, 1'b0);
        run_walk_phase({37'b0, 3'($urandom_range(0, TABLES - 1)), 12'b0}, 200, 1'b0);
    endtask

    // Receiver holds off while translates keep coming: the unit must back up
    // and drop s_tready without losing or reordering anything.
    task automatic test_backpressure();
        settle_idle();
        hold_cycles   = 300;
        sender_steady = 1'b1;
        repeat (40)
            send_word(CMD_TRANSLATE,
                      linear(4'($urandom), 9'($urandom_range(0, 3)), 9'($urandom),
                             9'($urandom), 9'($urandom), 12'($urandom)), rand64());
        sender_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        root_we         <= 1'b0;
        root_wdata      <= '0;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tuser         <= '0;
        root_copy        = '0;
        mismatches       = 0;
        words_sent       = 0;
        hold_cycles      = 0;
        sender_steady    = 1'b0;
        receiver_steady  = 1'b0;
        for (int n = 0; n < DEPTH; n++)
            entry_copy[n] = 64'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the store clearing sweep after reset is absorbed by the handshake
        test_empty_store();
        test_page_sizes();
        test_store_edges();
        test_random_walks();
        test_backpressure();

        settle_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_translations.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit, well past the slowest legal run.
    initial
    begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
